FILE: src/jsu_pkg.sv
// shared types, constants and the utf-8 encoder for the json string unescape unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // result record kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // largest result count of the main segment (one utf-8 sequence)
  localparam int unsigned SEG_BYTES   = 4;
  // bytes of a flushed lone high surrogate
  localparam int unsigned FLUSH_BYTES = 3;

  // input transfer payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last;
  } out_item_t;

  // encoded utf-8 sequence, byte 0 goes out first
  typedef struct packed {
    logic [2:0]                cnt;
    logic [SEG_BYTES-1:0][7:0] bytes;
  } utf8_t;

  // all results of one input item: optional flushed surrogate, then main segment
  typedef struct packed {
    logic                        a_en;
    logic [FLUSH_BYTES-1:0][7:0] a_bytes;
    logic [2:0]                  b_cnt;
    logic [1:0]                  b_kind;
    logic [SEG_BYTES-1:0][7:0]   b_bytes;
  } burst_t;

  // utf-8 encoding of one code point
  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.cnt      = 3'd1;
      r.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      r.cnt      = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.cnt      = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt      = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/json_string_unescape_utf8_unit.sv
// json string unescape to utf-8, one raw byte per input transfer
// the first result of an item is registered and appears in the cycle after its input transfer
// throughput: one item per cycle while each item gives at most one result and the output does not stall; an item
//   with n results holds the result register for n output transfers (n up to 6)
// reset: synchronous, returns the parser to idle waiting for an opening quote
// depends on jsu_pkg, jsu_decode, jsu_burst
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire jsu_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output jsu_pkg::out_item_t      out_data
);
  import jsu_pkg::*;

  burst_t burst;
  logic   take_ok;
  logic   accept;

  // input transfer when the result register frees up this cycle
  assign in_stall = !take_ok;
  assign accept   = in_valid && take_ok;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .burst   (burst)
  );

  jsu_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .burst     (burst),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .take_ok   (take_ok)
  );

endmodule

`default_nettype wire

FILE: src/jsu_decode.sv
// parse state machine: turns one raw byte into the result burst of that item
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire jsu_pkg::in_item_t in_data,
  output jsu_pkg::burst_t       burst
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [1:0] DIG_LAST = 2'd3;

  typedef enum logic [2:0] {
    M_IDLE,
    M_STR,
    M_ESC,
    M_HEX,
    M_PEND,
    M_PEND_BS,
    M_LHEX
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  dig_r, dig_nxt;
  logic [15:0] code_r, code_nxt;
  logic [9:0]  ph_r, ph_nxt;

  logic [4:0]  hx;
  logic [15:0] acc_sh;
  utf8_t       enc_code;
  utf8_t       enc_pair;
  logic [7:0]  b;

  // hex digit value, bit 4 marks a valid digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // single character escapes; anything else passes through
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  // next state and results of the current byte
  always_comb begin
    b        = in_data.in_byte;
    hx       = hex_val(b);
    acc_sh   = {code_r[11:0], hx[3:0]};
    enc_code = utf8_enc({5'd0, acc_sh});
    enc_pair = utf8_enc(21'h10000 + {1'b0, ph_r, acc_sh[9:0]});

    mode_nxt = mode_r;
    dig_nxt  = dig_r;
    code_nxt = code_r;
    ph_nxt   = ph_r;

    burst            = '0;
    burst.b_kind     = KIND_BYTE;
    // lone high surrogate as three bytes, used whenever a_en is set
    burst.a_bytes[0] = 8'hED;
    burst.a_bytes[1] = {4'hA, ph_r[9:6]};
    burst.a_bytes[2] = {2'b10, ph_r[5:0]};

    if (in_data.end_of_input) begin
      burst.b_cnt  = 3'd1;
      burst.b_kind = KIND_ERR;
      mode_nxt     = M_IDLE;
      code_nxt     = '0;
      ph_nxt       = '0;
    end else begin
      case (mode_r)
        M_STR, M_PEND: begin
          if (mode_r == M_PEND && b == CH_BSL) begin
            mode_nxt = M_PEND_BS;
          end else begin
            burst.a_en = (mode_r == M_PEND);
            ph_nxt     = '0;
            if (b == CH_QUOTE) begin
              burst.b_cnt  = 3'd1;
              burst.b_kind = KIND_END;
              mode_nxt     = M_IDLE;
              code_nxt     = '0;
            end else if (b == CH_BSL) begin
              mode_nxt = M_ESC;
            end else begin
              burst.b_cnt      = 3'd1;
              burst.b_bytes[0] = b;
              mode_nxt         = M_STR;
            end
          end
        end
        M_ESC, M_PEND_BS: begin
          if (b == CH_U) begin
            mode_nxt = (mode_r == M_ESC) ? M_HEX : M_LHEX;
            dig_nxt  = '0;
            code_nxt = '0;
          end else begin
            burst.a_en       = (mode_r == M_PEND_BS);
            ph_nxt           = '0;
            burst.b_cnt      = 3'd1;
            burst.b_bytes[0] = esc_map(b);
            mode_nxt         = M_STR;
          end
        end
        M_HEX, M_LHEX: begin
          if (!hx[4]) begin
            burst.b_cnt  = 3'd1;
            burst.b_kind = KIND_ERR;
            mode_nxt     = M_IDLE;
            code_nxt     = '0;
            ph_nxt       = '0;
          end else if (dig_r != DIG_LAST) begin
            code_nxt = acc_sh;
            dig_nxt  = dig_r + 2'd1;
          end else begin
            code_nxt = '0;
            if (mode_r == M_LHEX && acc_sh[15:10] == 6'b110111) begin
              // surrogate pair joins into one code point
              burst.b_cnt   = enc_pair.cnt;
              burst.b_bytes = enc_pair.bytes;
              ph_nxt        = '0;
              mode_nxt      = M_STR;
            end else begin
              burst.a_en = (mode_r == M_LHEX);
              if (acc_sh[15:10] == 6'b110110) begin
                ph_nxt   = acc_sh[9:0];
                mode_nxt = M_PEND;
              end else begin
                burst.b_cnt   = enc_code.cnt;
                burst.b_bytes = enc_code.bytes;
                ph_nxt        = '0;
                mode_nxt      = M_STR;
              end
            end
          end
        end
        default: begin
          // idle: only an opening quote starts a string
          code_nxt = '0;
          ph_nxt   = '0;
          if (b == CH_QUOTE) begin
            mode_nxt = M_STR;
          end else begin
            burst.b_cnt  = 3'd1;
            burst.b_kind = KIND_ERR;
            mode_nxt     = M_IDLE;
          end
        end
      endcase
    end
  end

  // parse state, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      dig_r  <= '0;
      code_r <= '0;
      ph_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dig_r  <= dig_nxt;
      code_r <= code_nxt;
      ph_r   <= ph_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/jsu_burst.sv
// result register: holds one item's burst and sends it one record per transfer
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_burst (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire jsu_pkg::burst_t   burst,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output jsu_pkg::out_item_t     out_data,
  output logic                   take_ok
);
  import jsu_pkg::*;

  burst_t     bst_r;
  logic       busy_r;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic [2:0] total_in;
  logic [2:0] b_off;
  logic       is_last;
  logic       xfer;

  // record count of held and incoming bursts
  assign total    = (bst_r.a_en ? 3'(FLUSH_BYTES) : 3'd0) + bst_r.b_cnt;
  assign total_in = (burst.a_en ? 3'(FLUSH_BYTES) : 3'd0) + burst.b_cnt;
  assign is_last  = (idx_r == total - 3'd1);
  assign xfer     = busy_r && !out_stall;
  assign take_ok  = !busy_r || (xfer && is_last);
  assign idx_nxt  = idx_r + 3'd1;

  // select current record: flushed surrogate first, then main segment
  always_comb begin
    b_off             = (bst_r.a_en && idx_r >= 3'(FLUSH_BYTES)) ? idx_r - 3'(FLUSH_BYTES)
                                                                   : idx_r;
    out_valid         = busy_r;
    out_data.last     = is_last;
    if (bst_r.a_en && idx_r < 3'(FLUSH_BYTES)) begin
      out_data.out_byte = bst_r.a_bytes[idx_r[1:0]];
      out_data.out_kind = KIND_BYTE;
    end else begin
      out_data.out_byte = bst_r.b_bytes[b_off[1:0]];
      out_data.out_kind = bst_r.b_kind;
    end
  end

  // busy flag and record index; empty once the last record is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load && take_ok) begin
      busy_r <= (total_in != 3'd0);
      idx_r  <= '0;
    end else if (xfer) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && take_ok) begin
      bst_r <= burst;
    end
  end

endmodule

`default_nettype wire
